@@ rtl/sdsr_pkg.sv @@
// ----------------------------------------------------------------------------
// Straight drive steering regulator package
// Shared word types and configuration register indexes.
// ----------------------------------------------------------------------------
package sdsr_pkg;

   localparam int WORD_WIDTH = 16;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic [WORD_WIDTH-1:0]        csr_data_type;
   typedef logic [2:0]                   csr_index_type;

   localparam csr_index_type CSR_GAIN_LATERAL     = 3'd0;
   localparam csr_index_type CSR_GAIN_HEADING     = 3'd1;
   localparam csr_index_type CSR_DRIVE_REVERSE    = 3'd2;
   localparam csr_index_type CSR_HEADING_QUADRANT = 3'd3;
   localparam csr_index_type CSR_CHANNEL_A_TRIM   = 3'd4;

   localparam logic [1:0] QUAD_UP    = 2'd0;
   localparam logic [1:0] QUAD_RIGHT = 2'd1;
   localparam logic [1:0] QUAD_DOWN  = 2'd2;
   localparam logic [1:0] QUAD_LEFT  = 2'd3;

   localparam logic [7:0] TRIM_RESET = 8'd2;
   localparam logic signed [7:0] FINISH_Y_OFFSET = -8'sd40;

endpackage

@@ rtl/straight_drive_steering_regulator_core.sv @@
// ----------------------------------------------------------------------------
// Straight drive steering regulator
// Turns position and heading samples into two wheel duty values.
// ----------------------------------------------------------------------------
// A beat on the req channel is either a start beat, which records the current
// map cell, or a sample beat. Every req beat yields exactly one rsp beat.
// A sample that must be regulated takes two passes through the one shared
// multiplier, first for the lateral gain and then for the heading gain, and a
// last step in S_DONE that clamps the error and forms the duty values. Such a
// sample goes through S_MUL_LAT, S_MUL_HEAD and S_DONE before its result is
// written to the output register. A start beat or a finished sample skips the
// multiplier and goes straight to S_DONE.
// The block takes one beat at a time: req_ready is high only while the
// sequencer is idle, so a regulated sample holds it busy until S_DONE is left.
// The result waits in the output register until rsp_ready is high; the next
// beat may already be accepted meanwhile, and its result is held back until
// the register is free.
// Configuration writes on the csr port are taken in any cycle and are
// expected only while the block is idle. Reset clears the sequencer, the
// gains, the mode bits and the recorded start cell, and sets the channel A
// trim to two.
// ----------------------------------------------------------------------------
module straight_drive_steering_regulator_core #(
   parameter int LATERAL_SHIFT       = 4,
   parameter int ANGLE_FRACTION_BITS = 8,
   parameter int MAX_SPEED           = 250
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_operation,
   input  logic signed [7:0]           req_pos_x,
   input  logic signed [7:0]           req_pos_y,
   input  logic signed [7:0]           req_heading_deg,
   input  logic [7:0]                  req_cell_x,
   input  logic [7:0]                  req_cell_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_pwm_a,
   output logic [7:0]                  rsp_pwm_b,
   output logic                        rsp_motor_forward,
   output logic signed [8:0]           rsp_steer_effort,
   output logic                        rsp_finished,
   input  logic                        csr_wr_en,
   input  sdsr_pkg::csr_index_type     csr_index,
   input  sdsr_pkg::csr_data_type      csr_wdata
);
   import sdsr_pkg::*;

   localparam int RAD_SHIFT  = 9 - ANGLE_FRACTION_BITS;
   localparam int HEAD_SHIFT = ANGLE_FRACTION_BITS - 4;
   localparam logic signed [WORD_WIDTH-1:0] MAX_W = WORD_WIDTH'(MAX_SPEED);
   localparam logic signed [WORD_WIDTH-1:0] MIN_W = -WORD_WIDTH'(MAX_SPEED);
   localparam logic signed [9:0] MAX_N = 10'(MAX_SPEED);

   typedef enum logic [1:0] {
      S_IDLE,
      S_MUL_LAT,
      S_MUL_HEAD,
      S_DONE
   } state_type;

   word_type        gain_lat_ff;
   word_type        gain_head_ff;
   logic            reverse_ff;
   logic [1:0]      quad_ff;
   logic [7:0]      trim_ff;
   logic [7:0]      start_col_ff;
   logic [7:0]      start_row_ff;

   state_type       state_ff, state_in;
   logic signed [7:0] rx_ff, rx_in;
   word_type        rad_ff, rad_in;
   word_type        lat_ff, lat_in;
   logic            zero_ff, zero_in;
   logic            fin_ff, fin_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      pwm_a_ff, pwm_a_in;
   logic [7:0]      pwm_b_ff, pwm_b_in;
   logic            fwd_ff, fwd_in;
   logic signed [8:0] effort_ff, effort_in;
   logic            finished_ff, finished_in;

   logic              accept;
   logic signed [7:0] rot_x, rot_y;
   logic              cell_moved;
   word_type          deg_w, deg9;
   logic              mul_en;
   word_type          mul_a, mul_b, product;
   word_type          head_term, diff;
   logic signed [9:0] err, left_spd, right_spd, chan_a, chan_b, chan_a_trim;
   logic              out_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      case (quad_ff)
         QUAD_UP: begin
            rot_x = req_pos_x;
            rot_y = req_pos_y;
         end
         QUAD_RIGHT: begin
            rot_x = -req_pos_y;
            rot_y = req_pos_x;
         end
         QUAD_DOWN: begin
            rot_x = -req_pos_x;
            rot_y = -req_pos_y;
         end
         default: begin
            rot_x = req_pos_y;
            rot_y = -req_pos_x;
         end
      endcase
   end

   assign cell_moved = (req_cell_x != start_col_ff) || (req_cell_y != start_row_ff);
   assign deg_w      = WORD_WIDTH'(req_heading_deg);
   assign deg9       = (deg_w <<< 3) + deg_w;

   assign mul_en = (state_ff == S_MUL_LAT) || (state_ff == S_MUL_HEAD);
   assign mul_a  = (state_ff == S_MUL_LAT) ? gain_lat_ff : gain_head_ff;
   assign mul_b  = (state_ff == S_MUL_LAT) ? WORD_WIDTH'(rx_ff) : rad_ff;

   sdsr_mul u_mul (
      .clock     (clock),
      .enable    (mul_en),
      .operand_a (mul_a),
      .operand_b (mul_b),
      .product   (product)
   );

   always_comb begin
      head_term = product >>> HEAD_SHIFT;
      diff      = lat_ff - head_term;
      if (diff > MAX_W) begin
         err = MAX_N;
      end else if (diff < MIN_W) begin
         err = -MAX_N;
      end else begin
         err = diff[9:0];
      end
      if (err > 10'sd0) begin
         right_spd = MAX_N;
         left_spd  = MAX_N - err;
      end else begin
         left_spd  = MAX_N;
         right_spd = MAX_N + err;
      end
      chan_a = reverse_ff ? left_spd : right_spd;
      chan_b = reverse_ff ? right_spd : left_spd;
      if (chan_a < $signed({2'b00, trim_ff})) begin
         chan_a_trim = 10'sd0;
      end else begin
         chan_a_trim = chan_a - $signed({2'b00, trim_ff});
      end
   end

   always_comb begin
      state_in     = state_ff;
      rx_in        = rx_ff;
      rad_in       = rad_ff;
      lat_in       = lat_ff;
      zero_in      = zero_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      pwm_a_in     = pwm_a_ff;
      pwm_b_in     = pwm_b_ff;
      fwd_in       = fwd_ff;
      effort_in    = effort_ff;
      finished_in  = finished_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rx_in   = rot_x;
               rad_in  = deg9 >>> RAD_SHIFT;
               fin_in  = req_operation && cell_moved && (rot_y > FINISH_Y_OFFSET);
               zero_in = !req_operation ||
                         (cell_moved && (rot_y > FINISH_Y_OFFSET));
               if (!req_operation || (cell_moved && (rot_y > FINISH_Y_OFFSET))) begin
                  state_in = S_DONE;
               end else begin
                  state_in = S_MUL_LAT;
               end
            end
         end
         S_MUL_LAT: begin
            state_in = S_MUL_HEAD;
         end
         S_MUL_HEAD: begin
            lat_in   = product >>> LATERAL_SHIFT;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               fwd_in       = !reverse_ff;
               finished_in  = fin_ff;
               if (zero_ff) begin
                  pwm_a_in  = 8'd0;
                  pwm_b_in  = 8'd0;
                  effort_in = 9'sd0;
               end else begin
                  pwm_a_in  = chan_a_trim[7:0];
                  pwm_b_in  = chan_b[7:0];
                  effort_in = err[8:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rx_ff       <= rx_in;
      rad_ff      <= rad_in;
      lat_ff      <= lat_in;
      zero_ff     <= zero_in;
      fin_ff      <= fin_in;
      pwm_a_ff    <= pwm_a_in;
      pwm_b_ff    <= pwm_b_in;
      fwd_ff      <= fwd_in;
      effort_ff   <= effort_in;
      finished_ff <= finished_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_col_ff <= 8'd0;
         start_row_ff <= 8'd0;
      end else if (accept && !req_operation) begin
         start_col_ff <= req_cell_x;
         start_row_ff <= req_cell_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_lat_ff  <= '0;
         gain_head_ff <= '0;
         reverse_ff   <= 1'b0;
         quad_ff      <= QUAD_UP;
         trim_ff      <= TRIM_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN_LATERAL:     gain_lat_ff  <= csr_wdata;
            CSR_GAIN_HEADING:     gain_head_ff <= csr_wdata;
            CSR_DRIVE_REVERSE:    reverse_ff   <= csr_wdata[0];
            CSR_HEADING_QUADRANT: quad_ff      <= csr_wdata[1:0];
            CSR_CHANNEL_A_TRIM:   trim_ff      <= csr_wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pwm_a         = pwm_a_ff;
   assign rsp_pwm_b         = pwm_b_ff;
   assign rsp_motor_forward = fwd_ff;
   assign rsp_steer_effort  = effort_ff;
   assign rsp_finished      = finished_ff;

   a_finish_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |->
         rsp_pwm_a == 8'd0 && rsp_pwm_b == 8'd0 && rsp_steer_effort == 9'sd0)
      else $error("finished result carries nonzero speeds");

   a_effort_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_steer_effort <= 9'(MAX_SPEED) &&
                    rsp_steer_effort >= -9'(MAX_SPEED))
      else $error("steering effort outside the clamp range");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second beat taken while a beat is in work");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pwm_a) &&
                                  $stable(rsp_pwm_b) && $stable(rsp_steer_effort))
      else $error("waiting result changed");

endmodule

@@ rtl/sdsr_mul.sv @@
// ----------------------------------------------------------------------------
// Shared gain multiplier
// Signed word by word product, wrapped to one word and registered.
// ----------------------------------------------------------------------------
module sdsr_mul (
   input  logic               clock,
   input  logic               enable,
   input  sdsr_pkg::word_type operand_a,
   input  sdsr_pkg::word_type operand_b,
   output sdsr_pkg::word_type product
);
   import sdsr_pkg::*;

   logic signed [2*WORD_WIDTH-1:0] full_product;
   word_type                       product_ff;

   assign full_product = operand_a * operand_b;
   assign product      = product_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= full_product[WORD_WIDTH-1:0];
      end
   end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// Straight drive steering regulator testbench
// A scoreboard predicts the duty values for every accepted req beat and
// compares each rsp beat against them in order. The stimulus starts with
// field extremes and the finish cases, then moves to random runs of a start
// beat and its samples under several register settings. Both handshake sides
// idle at random, the receiver holds off once for a long stretch, and the
// sender drains between settings.
// ----------------------------------------------------------------------------
module testbench;
   import sdsr_pkg::*;

   localparam int LATERAL_SHIFT       = 4;
   localparam int ANGLE_FRACTION_BITS = 8;
   localparam int MAX_SPEED           = 250;
   localparam int PHASES              = 8;
   localparam int BEATS_PER_PHASE     = 140;
   localparam int HOLD_CYCLES         = 80;
   localparam int STALL_LIMIT         = 2000;

   typedef enum logic {OP_START = 1'b0, OP_SAMPLE = 1'b1} op_kind_t;

   typedef struct {
      op_kind_t          operation;
      logic signed [7:0] pos_x;
      logic signed [7:0] pos_y;
      logic signed [7:0] heading_deg;
      logic [7:0]        cell_x;
      logic [7:0]        cell_y;
   } request_beat_t;

   typedef struct {
      logic [7:0]        pwm_a;
      logic [7:0]        pwm_b;
      logic              motor_forward;
      logic signed [8:0] steer_effort;
      logic              finished;
   } duty_beat_t;

   class duty_tracker;
      word_type          gain_lateral;
      word_type          gain_heading;
      logic              drive_reverse;
      logic [1:0]        heading_quadrant;
      logic [7:0]        channel_a_trim;
      logic [7:0]        start_col;
      logic [7:0]        start_row;
      duty_beat_t        pending_duties[$];
      int                failures;

      function new();
         gain_lateral     = '0;
         gain_heading     = '0;
         drive_reverse    = 1'b0;
         heading_quadrant = QUAD_UP;
         channel_a_trim   = TRIM_RESET;
         start_col        = '0;
         start_row        = '0;
         failures         = 0;
      endfunction

      function void write_register(csr_index_type idx, csr_data_type data);
         case (idx)
            CSR_GAIN_LATERAL: gain_lateral = data;
            CSR_GAIN_HEADING: gain_heading = data;
            CSR_DRIVE_REVERSE: drive_reverse = data[0];
            CSR_HEADING_QUADRANT: heading_quadrant = data[1:0];
            CSR_CHANNEL_A_TRIM: channel_a_trim = data[7:0];
            default: ;
         endcase
      endfunction

      function duty_beat_t predict_duty(request_beat_t r);
         duty_beat_t        d;
         logic signed [7:0] rel_x;
         logic signed [7:0] rel_y;
         word_type          rad;
         word_type          lat;
         word_type          head;
         word_type          err16;
         int                prod;
         int                effort;
         int                left;
         int                right;
         int                ch_a;
         int                ch_b;
         d.pwm_a         = '0;
         d.pwm_b         = '0;
         d.motor_forward = !drive_reverse;
         d.steer_effort  = '0;
         d.finished      = 1'b0;
         if (r.operation == OP_START) begin
            start_col = r.cell_x;
            start_row = r.cell_y;
            return d;
         end
         case (heading_quadrant)
            QUAD_UP: begin
               rel_x = r.pos_x;
               rel_y = r.pos_y;
            end
            QUAD_RIGHT: begin
               rel_x = -r.pos_y;
               rel_y = r.pos_x;
            end
            QUAD_DOWN: begin
               rel_x = -r.pos_x;
               rel_y = -r.pos_y;
            end
            default: begin
               rel_x = r.pos_y;
               rel_y = -r.pos_x;
            end
         endcase
         if ((r.cell_x != start_col || r.cell_y != start_row) &&
             rel_y > FINISH_Y_OFFSET) begin
            d.finished = 1'b1;
            return d;
         end
         prod = 9 * int'(r.heading_deg);
         rad  = 16'(prod >>> (9 - ANGLE_FRACTION_BITS));
         prod = int'(gain_lateral) * int'(rel_x);
         lat  = 16'(prod);
         lat  = lat >>> LATERAL_SHIFT;
         prod = int'(gain_heading) * int'(rad);
         head = 16'(prod);
         head = head >>> (ANGLE_FRACTION_BITS - 4);
         err16 = lat - head;
         effort = int'(err16);
         if (effort > MAX_SPEED) begin
            effort = MAX_SPEED;
         end else if (effort < -MAX_SPEED) begin
            effort = -MAX_SPEED;
         end
         if (effort > 0) begin
            right = MAX_SPEED;
            left  = MAX_SPEED - effort;
         end else begin
            left  = MAX_SPEED;
            right = MAX_SPEED + effort;
         end
         ch_a = drive_reverse ? left : right;
         ch_b = drive_reverse ? right : left;
         ch_a = (ch_a < int'(channel_a_trim)) ? 0 : ch_a - int'(channel_a_trim);
         d.pwm_a        = 8'(ch_a);
         d.pwm_b        = 8'(ch_b);
         d.steer_effort = 9'(effort);
         return d;
      endfunction

      function void note_request(request_beat_t r);
         pending_duties.push_back(predict_duty(r));
      endfunction

      function void check_response(duty_beat_t got);
         duty_beat_t want;
         if (pending_duties.size() == 0) begin
            $error("rsp beat arrived with no request outstanding");
            failures++;
            return;
         end
         want = pending_duties.pop_front();
         if (got.pwm_a !== want.pwm_a) begin
            $error("pwm_a: expected %0d, got %0d", want.pwm_a, got.pwm_a);
            failures++;
         end
         if (got.pwm_b !== want.pwm_b) begin
            $error("pwm_b: expected %0d, got %0d", want.pwm_b, got.pwm_b);
            failures++;
         end
         if (got.motor_forward !== want.motor_forward) begin
            $error("motor_forward: expected %0d, got %0d",
                   want.motor_forward, got.motor_forward);
            failures++;
         end
         if (got.steer_effort !== want.steer_effort) begin
            $error("steer_effort: expected %0d, got %0d",
                   want.steer_effort, got.steer_effort);
            failures++;
         end
         if (got.finished !== want.finished) begin
            $error("finished: expected %0d, got %0d", want.finished, got.finished);
            failures++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_operation;
   logic signed [7:0] req_pos_x;
   logic signed [7:0] req_pos_y;
   logic signed [7:0] req_heading_deg;
   logic [7:0]        req_cell_x;
   logic [7:0]        req_cell_y;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [7:0]        rsp_pwm_a;
   logic [7:0]        rsp_pwm_b;
   logic              rsp_motor_forward;
   logic signed [8:0] rsp_steer_effort;
   logic              rsp_finished;
   logic              csr_wr_en;
   csr_index_type     csr_index;
   csr_data_type      csr_wdata;

   duty_tracker sb = new;
   bit          idle_on = 1'b1;
   bit          hold_request = 1'b0;
   int          stall_cycles = 0;

   straight_drive_steering_regulator_core #(
      .LATERAL_SHIFT      (LATERAL_SHIFT),
      .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS),
      .MAX_SPEED          (MAX_SPEED)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_heading_deg  (req_heading_deg),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pwm_a        (rsp_pwm_a),
      .rsp_pwm_b        (rsp_pwm_b),
      .rsp_motor_forward(rsp_motor_forward),
      .rsp_steer_effort (rsp_steer_effort),
      .rsp_finished     (rsp_finished),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic signed [7:0] draw_signed_byte();
      if ($urandom_range(0, 9) != 0) return 8'($urandom);
      case ($urandom_range(0, 5))
         0: return -8'sd128;
         1: return 8'sd127;
         2: return -8'sd40;
         3: return -8'sd39;
         4: return 8'sd40;
         default: return 8'sd39;
      endcase
   endfunction

   task automatic send_beat(input op_kind_t op, input logic signed [7:0] px,
                            input logic signed [7:0] py, input logic signed [7:0] deg,
                            input logic [7:0] cx, input logic [7:0] cy);
      while (idle_on && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_pos_x       <= px;
      req_pos_y       <= py;
      req_heading_deg <= deg;
      req_cell_x      <= cx;
      req_cell_y      <= cy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_duties.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input csr_data_type data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      sb.write_register(idx, data);
      @(negedge clock);
   endtask

   task automatic apply_setting(input word_type gl, input word_type gh, input logic rev,
                                input logic [1:0] quad, input logic [7:0] trim);
      write_reg(CSR_GAIN_LATERAL, gl);
      write_reg(CSR_GAIN_HEADING, gh);
      write_reg(CSR_DRIVE_REVERSE, 16'(rev));
      write_reg(CSR_HEADING_QUADRANT, 16'(quad));
      write_reg(CSR_CHANNEL_A_TRIM, 16'(trim));
      csr_wr_en <= 1'b0;
   endtask

   task automatic run_phase(input int beats);
      int         sent;
      int         run_len;
      logic [7:0] cx;
      logic [7:0] cy;
      logic [7:0] nx;
      logic [7:0] ny;
      sent = 0;
      while (sent < beats) begin
         if ($urandom_range(0, 9) == 0) begin
            send_beat(op_kind_t'(1'($urandom)), draw_signed_byte(), draw_signed_byte(),
                      draw_signed_byte(), 8'($urandom), 8'($urandom));
            sent++;
         end else begin
            cx = 8'($urandom);
            cy = 8'($urandom);
            send_beat(OP_START, draw_signed_byte(), draw_signed_byte(),
                      draw_signed_byte(), cx, cy);
            run_len = $urandom_range(3, 12);
            repeat (run_len) begin
               nx = cx;
               ny = cy;
               if ($urandom_range(0, 3) == 0) begin
                  if ($urandom_range(0, 1) != 0) nx = cx + 8'd1;
                  else ny = cy - 8'd1;
               end
               send_beat(OP_SAMPLE, draw_signed_byte(), draw_signed_byte(),
                         draw_signed_byte(), nx, ny);
            end
            sent += run_len + 1;
         end
      end
   endtask

   initial begin
      rsp_ready = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_ready <= !(idle_on && $urandom_range(0, 99) < 23);
      end
   end

   always @(posedge clock) begin
      request_beat_t rq;
      duty_beat_t    rs;
      if (!reset) begin
         if (req_valid && req_ready) begin
            rq.operation   = op_kind_t'(req_operation);
            rq.pos_x       = req_pos_x;
            rq.pos_y       = req_pos_y;
            rq.heading_deg = req_heading_deg;
            rq.cell_x      = req_cell_x;
            rq.cell_y      = req_cell_y;
            sb.note_request(rq);
         end
         if (rsp_valid && rsp_ready) begin
            rs.pwm_a         = rsp_pwm_a;
            rs.pwm_b         = rsp_pwm_b;
            rs.motor_forward = rsp_motor_forward;
            rs.steer_effort  = rsp_steer_effort;
            rs.finished      = rsp_finished;
            sb.check_response(rs);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
               $display("[FAIL] regression broken");
               $finish;
            end
         end
      end
   end

   initial begin
      word_type gl;
      word_type gh;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_operation   = OP_START;
      req_pos_x       = '0;
      req_pos_y       = '0;
      req_heading_deg = '0;
      req_cell_x      = '0;
      req_cell_y      = '0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_GAIN_LATERAL;
      csr_wdata       = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Samples under the reset settings, before any start beat.
      send_beat(OP_SAMPLE, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0);
      send_beat(OP_SAMPLE, 8'sd0, 8'sd0, 8'sd0, 8'd3, 8'd0);
      drain();
      apply_setting(16'sd300, 16'sd200, 1'b0, QUAD_UP, 8'd2);
      send_beat(OP_START, -8'sd128, 8'sd127, -8'sd128, 8'd255, 8'd255);
      send_beat(OP_SAMPLE, 8'sd127, 8'sd0, 8'sd0, 8'd255, 8'd255);
      send_beat(OP_SAMPLE, -8'sd128, 8'sd0, 8'sd0, 8'd255, 8'd255);
      send_beat(OP_SAMPLE, 8'sd0, 8'sd0, 8'sd127, 8'd255, 8'd255);
      send_beat(OP_SAMPLE, 8'sd0, 8'sd0, -8'sd128, 8'd255, 8'd255);
      send_beat(OP_SAMPLE, 8'sd1, -8'sd1, 8'sd1, 8'd255, 8'd255);
      send_beat(OP_SAMPLE, 8'sd3, -8'sd40, 8'sd5, 8'd0, 8'd255);
      send_beat(OP_SAMPLE, 8'sd3, -8'sd39, 8'sd5, 8'd0, 8'd255);
      send_beat(OP_SAMPLE, -8'sd7, 8'sd127, -8'sd9, 8'd255, 8'd0);
      send_beat(OP_SAMPLE, -8'sd7, 8'sd127, -8'sd9, 8'd255, 8'd255);
      send_beat(OP_SAMPLE, 8'sd20, -8'sd128, 8'sd30, 8'd0, 8'd0);
      send_beat(OP_START, 8'sd0, 8'sd0, 8'sd0, 8'd0, 8'd0);
      send_beat(OP_SAMPLE, 8'sd5, 8'sd10, -8'sd3, 8'd0, 8'd0);
      send_beat(OP_SAMPLE, 8'sd5, 8'sd10, -8'sd3, 8'd0, 8'd1);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         idle_on = (p != 2);
         case (p)
            0: apply_setting(16'sh7FFF, 16'sh8000, 1'b0, QUAD_UP, 8'd0);
            1: apply_setting(16'sh8000, 16'sh7FFF, 1'b1, QUAD_RIGHT, 8'd255);
            default: begin
               if (p % 2 == 0) begin
                  gl = 16'($urandom_range(0, 128));
                  gl = gl - 16'sd64;
                  gh = 16'($urandom_range(0, 128));
                  gh = gh - 16'sd64;
               end else begin
                  gl = 16'($urandom);
                  gh = 16'($urandom);
               end
               apply_setting(gl, gh, 1'($urandom), 2'(p), 8'($urandom));
            end
         endcase
         if (p == 4) hold_request = 1'b1;
         run_phase(BEATS_PER_PHASE);
      end

      drain();
      repeat (16) @(posedge clock);
      if (sb.failures == 0 && sb.pending_duties.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

@@ straight_drive_steering_regulator_core.f @@
rtl/sdsr_pkg.sv
rtl/sdsr_mul.sv
rtl/straight_drive_steering_regulator_core.sv
tb/testbench.sv
